FILE: hdl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg - shared types and constants of the line rasterizer
// Field widths, register indexes and the line command passed from the
// front end through the queue to the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  // Field widths
  localparam int IN_COORD_W  = 8;
  localparam int COORD_W     = 4;
  localparam int COLOR_W     = 24;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_TDATA_W  = 4 * IN_COORD_W + COLOR_W;
  localparam int OUT_TDATA_W = 2 * COORD_W + COLOR_W;

  // Error term: spans -(2^COORD_W - 1) .. 2^COORD_W - 1, plus a guard bit
  localparam int ERR_W = COORD_W + 2;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;

  // Default matrix size
  localparam int GRID_SIZE_DEF = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_COLUMN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROW    = 2'd1;

  // Classified line command, major axis p, minor axis q
  typedef struct packed {
    logic [COORD_W-1:0] p0;
    logic [COORD_W-1:0] p1;
    logic [COORD_W-1:0] q0;
    logic [COORD_W-1:0] dmaj;
    logic [COORD_W-1:0] dmin;
    logic               steep;
    logic               q_up;
    logic [COLOR_W-1:0] color;
  } blr_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front - command classifier
// Holds the matrix limits, range-checks each request and turns it into a
// major/minor axis command with endpoints ordered along the major axis.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_front #(
  parameter int GRID_SIZE = blr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [blr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output blr_pkg::blr_cmd_t                   cmd,
  output logic                                cmd_keep
);

  localparam int CW       = blr_pkg::COORD_W;
  localparam int IW       = blr_pkg::IN_COORD_W;
  localparam int GRID_MAX = GRID_SIZE - 1;

  logic [CW-1:0] max_column_r;
  logic [CW-1:0] max_row_r;
  logic [CW-1:0] lim_x;
  logic [CW-1:0] lim_y;

  logic [IW-1:0] ax_w, ay_w, bx_w, by_w;
  logic [CW-1:0] ax, ay, bx, by;
  logic [CW-1:0] dx, dy;
  logic [CW-1:0] pa, qa, pb, qb;
  logic          steep;

  // Write the limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_column_r <= '1;
      max_row_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blr_pkg::REG_MAX_COLUMN: max_column_r <= cfg_wdata;
        blr_pkg::REG_MAX_ROW:    max_row_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the limits to the matrix size
  assign lim_x = (32'(max_column_r) < GRID_MAX) ? max_column_r : CW'(GRID_MAX);
  assign lim_y = (32'(max_row_r) < GRID_MAX) ? max_row_r : CW'(GRID_MAX);

  // Unpack the request
  assign ax_w = in_tdata[0*IW +: IW];
  assign ay_w = in_tdata[1*IW +: IW];
  assign bx_w = in_tdata[2*IW +: IW];
  assign by_w = in_tdata[3*IW +: IW];

  // Drop lines that leave the matrix
  assign cmd_keep = (ax_w <= IW'(lim_x)) && (ay_w <= IW'(lim_y)) &&
                    (bx_w <= IW'(lim_x)) && (by_w <= IW'(lim_y));

  // In range every coordinate fits the narrow width
  assign ax = ax_w[CW-1:0];
  assign ay = ay_w[CW-1:0];
  assign bx = bx_w[CW-1:0];
  assign by = by_w[CW-1:0];

  assign dx    = (bx > ax) ? bx - ax : ax - bx;
  assign dy    = (by > ay) ? by - ay : ay - by;
  assign steep = dy > dx;

  // Map onto major (p) and minor (q) axes
  assign pa = steep ? ay : ax;
  assign qa = steep ? ax : ay;
  assign pb = steep ? by : bx;
  assign qb = steep ? bx : by;

  // Order the endpoints along the major axis
  always_comb begin
    cmd.steep = steep;
    cmd.dmaj  = steep ? dy : dx;
    cmd.dmin  = steep ? dx : dy;
    cmd.color = in_tdata[4*IW +: blr_pkg::COLOR_W];
    if (pa > pb) begin
      cmd.p0   = pb;
      cmd.p1   = pa;
      cmd.q0   = qb;
      cmd.q_up = qb < qa;
    end else begin
      cmd.p0   = pa;
      cmd.p1   = pb;
      cmd.q0   = qa;
      cmd.q_up = qa < qb;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blr_queue.sv
// ----------------------------------------------------------------------------
// blr_queue - command queue
// Small first-in first-out store that decouples the classifier from the
// pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire blr_pkg::blr_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output blr_pkg::blr_cmd_t      pop_cmd,
  output logic                   empty
);

  localparam int DEPTH = blr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blr_pkg::blr_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blr_back.sv
// ----------------------------------------------------------------------------
// blr_back - Bresenham stepper
// Loads one command from the queue and walks the major axis, one pixel a
// cycle, into an output register that holds while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire blr_pkg::blr_cmd_t               q_cmd,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [blr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int EW = blr_pkg::ERR_W;

  logic                        busy_r, busy_nxt;
  logic [CW-1:0]               p_r, p_nxt;
  logic [CW-1:0]               q_r, q_nxt;
  logic signed [EW-1:0]        err_r, err_nxt;
  logic [CW-1:0]               p1_r, dmaj_r, dmin_r;
  logic                        steep_r, q_up_r;
  logic [blr_pkg::COLOR_W-1:0] color_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [CW-1:0]               out_x_r, out_y_r;
  logic [blr_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  logic                        step;
  logic                        at_end;
  logic signed [EW-1:0]        err_dec;

  assign q_pop   = !busy_r && !q_empty;
  assign step    = busy_r && (!out_valid_r || out_tready);
  assign at_end  = (p_r == p1_r);
  assign err_dec = err_r - $signed({{(EW-CW){1'b0}}, dmin_r});

  // Walk one major-axis step
  always_comb begin
    busy_nxt      = busy_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      p_nxt    = q_cmd.p0;
      q_nxt    = q_cmd.q0;
      err_nxt  = $signed({{(EW-CW+1){1'b0}}, q_cmd.dmaj[CW-1:1]});
    end else if (step) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = !at_end;
      p_nxt         = p_r + 1'b1;
      if (err_dec[EW-1]) begin
        q_nxt   = q_up_r ? q_r + 1'b1 : q_r - 1'b1;
        err_nxt = err_dec + $signed({{(EW-CW){1'b0}}, dmaj_r});
      end else begin
        err_nxt = err_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the walk position and line data
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    err_r <= err_nxt;
    if (q_pop) begin
      p1_r    <= q_cmd.p1;
      dmaj_r  <= q_cmd.dmaj;
      dmin_r  <= q_cmd.dmin;
      steep_r <= q_cmd.steep;
      q_up_r  <= q_cmd.q_up;
      color_r <= q_cmd.color;
    end
  end

  // Load the pixel into the output register
  always_ff @(posedge clk) begin
    if (step) begin
      out_x_r     <= steep_r ? q_r : p_r;
      out_y_r     <= steep_r ? p_r : q_r;
      out_color_r <= color_r;
      out_last_r  <= at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_color_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer - line drawing for a small LED matrix
// Classifies line requests, queues them and steps out one pixel write per
// major-axis coordinate.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry command queue has room. A line
// whose endpoints leave the limits (max_column, max_row, clamped to
// GRID_SIZE-1) is dropped and gives no pixels. For an accepted line of n
// pixels (n = major delta + 1, 1 to 16) the stepper pops the command, then
// gives one pixel per cycle, as set by the single error-term update loop.
// Pixels come out by rising major coordinate, tlast on the final one; a
// stalled sink holds the stepper. The user must write the limit registers
// (cfg_we/cfg_index/cfg_wdata) only while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int GRID_SIZE = blr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Limit registers
  input  wire logic                            cfg_we,
  input  wire logic [blr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Line requests
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], color[55:32]
  input  wire logic [blr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Pixel writes
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // pix_x[3:0], pix_y[7:4], pix_color[31:8]
  output logic [blr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  blr_pkg::blr_cmd_t front_cmd;
  blr_pkg::blr_cmd_t queue_cmd;
  logic              front_keep;
  logic              queue_full;
  logic              queue_empty;
  logic              queue_pop;
  logic              queue_push;

  assign in_tready  = !queue_full;
  assign queue_push = in_tvalid && in_tready && front_keep;

  blr_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (front_cmd),
    .cmd_keep  (front_keep)
  );

  blr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (queue_push),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_cmd  (queue_cmd),
    .empty    (queue_empty)
  );

  blr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (queue_empty),
    .q_cmd      (queue_cmd),
    .q_pop      (queue_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/blr_checker.sv
// ----------------------------------------------------------------------------
// blr_checker - port-level checks of the line rasterizer
// Watches reset behaviour and the pixel channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tready,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [blr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            out_tlast
);

  // No pixel pending straight after reset
  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pixel valid after reset");

  // Empty queue takes a request straight after reset
  a_reset_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("request not taken after reset");

  // A stalled pixel stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel changed");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

`default_nettype wire
